FILE: hw/rtl/ast_pkg.sv
// Shared types and codes for the array set table.
package ast_pkg;

   localparam logic [2:0] CMD_CLEAR      = 3'd0;
   localparam logic [2:0] CMD_INSERT     = 3'd1;
   localparam logic [2:0] CMD_REMOVE     = 3'd2;
   localparam logic [2:0] CMD_REMOVE_ANY = 3'd3;
   localparam logic [2:0] CMD_FIND       = 3'd4;

   localparam logic [2:0] ST_DONE      = 3'd0;
   localparam logic [2:0] ST_PRESENT   = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;

   localparam logic [7:0] NO_POSITION = 8'hFF;

   // read address select
   localparam logic [1:0] ADDR_FIRST = 2'd0;
   localparam logic [1:0] ADDR_LAST  = 2'd1;
   localparam logic [1:0] ADDR_NEXT  = 2'd2;
   localparam logic [1:0] ADDR_SKIP  = 2'd3;

   typedef struct packed {
      logic       take;
      logic       do_clear;
      logic       do_hit;
      logic       do_miss;
      logic       do_pop;
      logic       scan_next;
      logic       shift_step;
      logic       shift_end;
      logic       rsp_load;
      logic [1:0] addr_sel;
   } ctl_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       empty;
      logic       match;
      logic       scan_last;
      logic       shift_last;
      logic       out_free;
   } sts_type;

endpackage

FILE: hw/rtl/ast_ram.sv
// Generic simple dual-port RAM with registered read.
module ast_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/ast_ctrl.sv
// Request sequencer for the array set table.
module ast_ctrl import ast_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output ctl_type ctl
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_SCAN     = 3'd2;
   localparam logic [2:0] S_SHIFT    = 3'd3;
   localparam logic [2:0] S_POP      = 3'd4;
   localparam logic [2:0] S_FINISH   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.take = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (sts.cmd)
               CMD_CLEAR: begin
                  ctl.do_clear = 1'b1;
                  state_in     = S_FINISH;
               end
               CMD_INSERT, CMD_REMOVE, CMD_FIND: begin
                  ctl.addr_sel = ADDR_FIRST;
                  if (sts.empty) begin
                     ctl.do_miss = 1'b1;
                     state_in    = S_FINISH;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               CMD_REMOVE_ANY: begin
                  ctl.addr_sel = ADDR_LAST;
                  if (sts.empty) begin
                     ctl.do_miss = 1'b1;
                     state_in    = S_FINISH;
                  end else begin
                     state_in = S_POP;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_SCAN: begin
            ctl.addr_sel = ADDR_NEXT;
            if (sts.match) begin
               ctl.do_hit = 1'b1;
               if (sts.cmd == CMD_REMOVE && !sts.scan_last) begin
                  state_in = S_SHIFT;
               end else begin
                  state_in = S_FINISH;
               end
            end else if (sts.scan_last) begin
               ctl.do_miss = 1'b1;
               state_in    = S_FINISH;
            end else begin
               ctl.scan_next = 1'b1;
            end
         end
         S_SHIFT: begin
            ctl.addr_sel = ADDR_SKIP;
            if (sts.shift_last) begin
               ctl.shift_end = 1'b1;
               state_in      = S_FINISH;
            end else begin
               ctl.shift_step = 1'b1;
            end
         end
         S_POP: begin
            ctl.do_pop = 1'b1;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (sts.out_free) begin
               ctl.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/ast_dpath.sv
// Key store, scan pointer, count and result registers.
module ast_dpath import ast_pkg::*; #(
   parameter int CAPACITY = 128,
   parameter int KEY_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [2:0]         req_cmd,
   input  logic signed [31:0] req_key,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic signed [7:0]  rsp_position,
   output logic signed [31:0] rsp_key_out,
   output logic [7:0]         rsp_count,
   input  ctl_type            ctl,
   output sts_type            sts
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);

   logic [2:0]          cmd_ff, cmd_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic [2:0]          status_ff, status_in;
   logic [7:0]          pos_ff, pos_in;
   logic [KEY_BITS-1:0] removed_ff, removed_in;

   logic                rsp_valid_ff;
   logic [2:0]          rsp_status_ff;
   logic [7:0]          rsp_pos_ff;
   logic [31:0]         rsp_key_ff;
   logic [7:0]          rsp_count_ff;

   logic                wr_en;
   logic [IW-1:0]       wr_addr;
   logic [KEY_BITS-1:0] wr_data;
   logic [IW-1:0]       rd_addr;
   logic [KEY_BITS-1:0] rd_data;

   logic signed [63:0]  key_wide;
   logic [31:0]         idx_wide;
   logic [31:0]         count_wide;
   logic [31:0]         last_wide;
   logic [CW-1:0]       count_m1;
   logic [CW-1:0]       idx_ext;
   logic                full;
   logic                shifting;

   assign key_wide   = 64'(req_key);
   assign count_m1   = count_ff - CW'(1);
   assign idx_ext    = CW'(idx_ff);
   assign idx_wide   = 32'(idx_ff);
   assign count_wide = 32'(count_ff);
   assign last_wide  = 32'(count_m1);
   assign full       = (count_ff == CW'(CAPACITY));
   assign shifting   = ctl.shift_step | ctl.shift_end;

   always_comb begin
      case (ctl.addr_sel)
         ADDR_FIRST: rd_addr = '0;
         ADDR_LAST:  rd_addr = count_m1[IW-1:0];
         ADDR_NEXT:  rd_addr = idx_ff + IW'(1);
         ADDR_SKIP:  rd_addr = idx_ff + IW'(2);
         default:    rd_addr = '0;
      endcase
   end

   assign wr_en   = shifting | (ctl.do_miss && cmd_ff == CMD_INSERT && !full);
   assign wr_addr = shifting ? idx_ff : count_ff[IW-1:0];
   assign wr_data = shifting ? rd_data : key_ff;

   ast_ram #(
      .WIDTH(KEY_BITS),
      .DEPTH(CAPACITY)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      cmd_in     = cmd_ff;
      key_in     = key_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      status_in  = status_ff;
      pos_in     = pos_ff;
      removed_in = removed_ff;

      if (ctl.take) begin
         cmd_in     = req_cmd;
         key_in     = key_wide[KEY_BITS-1:0];
         idx_in     = '0;
         status_in  = ST_DONE;
         pos_in     = NO_POSITION;
         removed_in = '0;
      end
      if (ctl.do_clear) begin
         count_in = '0;
      end
      if (ctl.do_hit) begin
         pos_in = idx_wide[7:0];
         if (cmd_ff == CMD_INSERT) begin
            status_in = ST_PRESENT;
         end
         if (cmd_ff == CMD_REMOVE) begin
            removed_in = rd_data;
            if (sts.scan_last) begin
               count_in = count_m1;
            end
         end
      end
      if (ctl.do_miss) begin
         case (cmd_ff)
            CMD_INSERT: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  pos_in   = count_wide[7:0];
                  count_in = count_ff + CW'(1);
               end
            end
            CMD_REMOVE_ANY: status_in = ST_EMPTY;
            default:        status_in = ST_NOT_FOUND;
         endcase
      end
      if (ctl.scan_next || ctl.shift_step) begin
         idx_in = idx_ff + IW'(1);
      end
      if (ctl.shift_end) begin
         count_in = count_m1;
      end
      if (ctl.do_pop) begin
         removed_in = rd_data;
         pos_in     = last_wide[7:0];
         count_in   = count_m1;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      key_ff     <= key_in;
      idx_ff     <= idx_in;
      status_ff  <= status_in;
      pos_ff     <= pos_in;
      removed_ff <= removed_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (ctl.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_pos_ff    <= pos_ff;
         rsp_key_ff    <= 32'(removed_ff);
         rsp_count_ff  <= count_wide[7:0];
      end
   end

   assign sts.cmd        = cmd_ff;
   assign sts.empty      = (count_ff == '0);
   assign sts.match      = (rd_data == key_ff);
   assign sts.scan_last  = ((idx_ext + CW'(1)) == count_ff);
   assign sts.shift_last = ((idx_ext + CW'(2)) == count_ff);
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_position = signed'(rsp_pos_ff);
   assign rsp_key_out  = signed'(rsp_key_ff);
   assign rsp_count    = rsp_count_ff;

endmodule

FILE: hw/rtl/array_set_table.sv
// Top level of the array set table: ordered set of distinct keys, linear search.
//
//   channel   direction  signals                                        width
//   req       in         req_valid/req_ready, req_cmd, req_key          3, 32
//   rsp       out        rsp_valid/rsp_ready, rsp_status, rsp_position,
//                        rsp_key_out, rsp_count                         3, 8, 32, 8
//
// One request at a time. Clear and unused codes go from dispatch straight to finish; remove-any
// reads the last entry and pops it. Insert, find and remove scan from the first entry; remove
// then moves each later entry down by one. The single read port of the key store, one entry
// per cycle, sets the length of the scan and of the shift.
// Reset clears the count and the controller; the store needs no clearing pass.
// A finished response waits in the output register; the next request is taken meanwhile.
module array_set_table import ast_pkg::*; #(
   parameter int CAPACITY = 128,
   parameter int KEY_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_cmd,
   input  logic signed [31:0] req_key,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic signed [7:0]  rsp_position,
   output logic signed [31:0] rsp_key_out,
   output logic [7:0]         rsp_count
);

   ctl_type ctl;
   sts_type sts;

   ast_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .sts      (sts),
      .ctl      (ctl)
   );

   ast_dpath #(
      .CAPACITY(CAPACITY),
      .KEY_BITS(KEY_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_cmd     (req_cmd),
      .req_key     (req_key),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_status  (rsp_status),
      .rsp_position(rsp_position),
      .rsp_key_out (rsp_key_out),
      .rsp_count   (rsp_count),
      .ctl         (ctl),
      .sts         (sts)
   );

   // one request in flight
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while one is in progress");

   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.do_clear, ctl.do_hit, ctl.do_miss, ctl.do_pop,
                ctl.scan_next, ctl.shift_step, ctl.shift_end}))
      else $error("conflicting datapath actions");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_count == 8'd0)
      else $error("empty status with nonzero count");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_count == 8'(CAPACITY))
      else $error("full status with count below capacity");

endmodule
